/* rtl/core/sobgm_pkg.sv */
package sobgm_pkg;

  // image geometry
  localparam int IMAGE_WIDTH  = 512;
  localparam int IMAGE_HEIGHT = 512;
  localparam int COL_W        = $clog2(IMAGE_WIDTH);
  localparam int ROW_W        = $clog2(IMAGE_HEIGHT);

  // datapath widths
  localparam int PIX_W  = 8;
  localparam int POS_W  = 9;   // width of the reported row and column
  localparam int SUM3_W = 10;  // 1,2,1 weighted sum of three pixels
  localparam int GRAD_W = 11;  // signed difference of two weighted sums
  localparam int SQ_W   = 20;  // square of one gradient
  localparam int MAG2_W = 21;  // sum of both squares

  // square root cells: one result bit per cell
  localparam int ROOT_W     = 8;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SQRT_CELLS = ROOT_W;

  // position of a result inside the frame
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } tag_t;

  // data handed from one square root cell to the next
  typedef struct packed {
    logic              sat;
    tag_t              tag;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sqrt_t;

endpackage

/* rtl/core/sobgm_window.sv */
module sobgm_window (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 advance,
  input  logic                                 accept,
  input  logic [sobgm_pkg::PIX_W-1:0]          pixel,
  input  logic                                 frame_start,
  output logic                                 grad_valid,
  output logic signed [sobgm_pkg::GRAD_W-1:0]  gx,
  output logic signed [sobgm_pkg::GRAD_W-1:0]  gy,
  output sobgm_pkg::tag_t                      grad_tag
);

  localparam int COL_W = sobgm_pkg::COL_W;
  localparam int ROW_W = sobgm_pkg::ROW_W;
  localparam int PIX_W = sobgm_pkg::PIX_W;
  localparam int S_W   = sobgm_pkg::SUM3_W;
  localparam int G_W   = sobgm_pkg::GRAD_W;

  logic [ROW_W-1:0] row_pos;
  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_cur;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_pos_next;
  logic [COL_W-1:0] col_pos_next;
  logic [ROW_W-1:0] row_less;
  logic [COL_W-1:0] col_less;

  // line stores: upper row in the high byte, middle row in the low byte
  logic [2*PIX_W-1:0] line_mem [sobgm_pkg::IMAGE_WIDTH];
  logic [2*PIX_W-1:0] line_rd;

  logic               a_valid;
  logic               a_emit;
  logic [PIX_W-1:0]   a_px;
  logic [COL_W-1:0]   a_addr;
  sobgm_pkg::tag_t    a_tag;

  logic [PIX_W-1:0]   win [3][3];
  logic [PIX_W-1:0]   up;
  logic [PIX_W-1:0]   mid;
  logic [S_W-1:0]     left_sum;
  logic [S_W-1:0]     right_sum;
  logic [S_W-1:0]     top_sum;
  logic [S_W-1:0]     bot_sum;

  // position of the incoming pixel
  always_comb begin
    row_cur = frame_start ? '0 : row_pos;
    col_cur = frame_start ? '0 : col_pos;
    row_less = row_cur - 1'b1;
    col_less = col_cur - 1'b1;
    if (col_cur == COL_W'(sobgm_pkg::IMAGE_WIDTH - 1)) begin
      col_pos_next = '0;
      if (row_cur == ROW_W'(sobgm_pkg::IMAGE_HEIGHT - 1)) begin
        row_pos_next = '0;
      end else begin
        row_pos_next = row_cur + 1'b1;
      end
    end else begin
      col_pos_next = col_cur + 1'b1;
      row_pos_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept) begin
      row_pos <= row_pos_next;
      col_pos <= col_pos_next;
    end
  end

  // stage a: line store read, pixel and position held
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_px         <= pixel;
      a_addr       <= col_cur;
      a_emit       <= (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
      a_tag.row    <= POS_W_CAST_ROW(row_less);
      a_tag.col    <= POS_W_CAST_COL(col_less);
      a_tag.last   <= (row_cur == ROW_W'(sobgm_pkg::IMAGE_HEIGHT - 1)) &&
                      (col_cur == COL_W'(sobgm_pkg::IMAGE_WIDTH - 1));
    end
  end

  // contents written before reset are never part of a result: the first two
  // rows of every frame refill both line stores before they are used
  always_ff @(posedge clk) begin
    if (advance) begin
      line_rd <= line_mem[col_cur];
    end
    if (advance && a_valid) begin
      line_mem[a_addr] <= {line_rd[PIX_W-1:0], a_px};
    end
  end

  assign up  = line_rd[2*PIX_W-1:PIX_W];
  assign mid = line_rd[PIX_W-1:0];

  // window shift, new column enters on the right
  always_ff @(posedge clk) begin
    if (advance && a_valid) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= up;
      win[1][2] <= mid;
      win[2][2] <= a_px;
    end
  end

  // weighted sums over the shifted window
  always_comb begin
    left_sum  = S_W'(win[0][1]) + S_W'({win[1][1], 1'b0}) + S_W'(win[2][1]);
    right_sum = S_W'(up) + S_W'({mid, 1'b0}) + S_W'(a_px);
    top_sum   = S_W'(win[0][1]) + S_W'({win[0][2], 1'b0}) + S_W'(up);
    bot_sum   = S_W'(win[2][1]) + S_W'({win[2][2], 1'b0}) + S_W'(a_px);
  end

  // stage b: gradients
  always_ff @(posedge clk) begin
    if (rst) begin
      grad_valid <= 1'b0;
    end else if (advance) begin
      grad_valid <= a_valid && a_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gx       <= $signed(G_W'(left_sum) - G_W'(right_sum));
      gy       <= $signed(G_W'(top_sum) - G_W'(bot_sum));
      grad_tag <= a_tag;
    end
  end

  // reported positions keep their low bits only
  function automatic logic [sobgm_pkg::POS_W-1:0] POS_W_CAST_ROW(
    input logic [ROW_W-1:0] v
  );
    return sobgm_pkg::POS_W'(v);
  endfunction

  function automatic logic [sobgm_pkg::POS_W-1:0] POS_W_CAST_COL(
    input logic [COL_W-1:0] v
  );
    return sobgm_pkg::POS_W'(v);
  endfunction

endmodule

/* rtl/core/sobgm_sqrt_cell.sv */
module sobgm_sqrt_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             d_valid,
  input  sobgm_pkg::sqrt_t d,
  output logic             q_valid,
  output sobgm_pkg::sqrt_t q
);

  localparam int REM_W  = sobgm_pkg::REM_W;
  localparam int ROOT_W = sobgm_pkg::ROOT_W;
  localparam int RAD_W  = sobgm_pkg::RAD_W;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  sobgm_pkg::sqrt_t q_next;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {d.rem, d.rad[RAD_W-1:RAD_W-2]};
    trial  = (REM_W + 2)'({d.root, 2'b01});
    q_next = d;
    q_next.rad = {d.rad[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      q_next.rem  = REM_W'(rem_sh - trial);
      q_next.root = {d.root[ROOT_W-2:0], 1'b1};
    end else begin
      q_next.rem  = REM_W'(rem_sh);
      q_next.root = {d.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (advance) begin
      q_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      q <= q_next;
    end
  end

endmodule

/* rtl/core/sobel_gradient_magnitude.sv */
// path: an accepted pixel passes the line store read, gradient, square, 8 square
// root cells and output registers before its result leaves the output register
// throughput: one pixel per cycle; the whole pipeline holds only while a
// waiting result is stalled at the output
// reset: synchronous, clears position counters and all stage valid bits
module sobel_gradient_magnitude (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [sobgm_pkg::PIX_W-1:0]    pixel,
  input  logic                           frame_start,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sobgm_pkg::ROOT_W-1:0]   magnitude,
  output logic [sobgm_pkg::POS_W-1:0]    out_row,
  output logic [sobgm_pkg::POS_W-1:0]    out_col,
  output logic                           last
);

  localparam int G_W    = sobgm_pkg::GRAD_W;
  localparam int SQ_W   = sobgm_pkg::SQ_W;
  localparam int M_W    = sobgm_pkg::MAG2_W;
  localparam int RAD_W  = sobgm_pkg::RAD_W;
  localparam int CELLS  = sobgm_pkg::SQRT_CELLS;

  logic                     advance;
  logic                     accept;
  logic                     grad_valid;
  logic signed [G_W-1:0]    gx;
  logic signed [G_W-1:0]    gy;
  sobgm_pkg::tag_t          grad_tag;

  logic signed [2*G_W-1:0]  gx_sq;
  logic signed [2*G_W-1:0]  gy_sq;
  logic                     sq_valid;
  logic [SQ_W-1:0]          sqx;
  logic [SQ_W-1:0]          sqy;
  sobgm_pkg::tag_t          sq_tag;
  logic [M_W-1:0]           mag2;

  logic                     cell_valid [CELLS+1];
  sobgm_pkg::sqrt_t         cell_data  [CELLS+1];

  // pipeline moves whenever the output register is free or being taken
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  sobgm_window u_window (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .accept      (accept),
    .pixel       (pixel),
    .frame_start (frame_start),
    .grad_valid  (grad_valid),
    .gx          (gx),
    .gy          (gy),
    .grad_tag    (grad_tag)
  );

  // squares of both gradients
  assign gx_sq = gx * gx;
  assign gy_sq = gy * gy;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (advance) begin
      sq_valid <= grad_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sqx    <= gx_sq[SQ_W-1:0];
      sqy    <= gy_sq[SQ_W-1:0];
      sq_tag <= grad_tag;
    end
  end

  // sum of squares feeds the first cell; roots above 255 saturate
  assign mag2 = M_W'(sqx) + M_W'(sqy);

  always_comb begin
    cell_valid[0]     = sq_valid;
    cell_data[0].sat  = |mag2[M_W-1:RAD_W];
    cell_data[0].tag  = sq_tag;
    cell_data[0].rem  = '0;
    cell_data[0].root = '0;
    cell_data[0].rad  = mag2[RAD_W-1:0];
  end

  // square root chain, one root bit per cell
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    sobgm_sqrt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .d_valid (cell_valid[k]),
      .d       (cell_data[k]),
      .q_valid (cell_valid[k+1]),
      .q       (cell_data[k+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= cell_valid[CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      magnitude <= cell_data[CELLS].sat ? '1 : cell_data[CELLS].root;
      out_row   <= cell_data[CELLS].tag.row;
      out_col   <= cell_data[CELLS].tag.col;
      last      <= cell_data[CELLS].tag.last;
    end
  end

endmodule
